/* hw/rtl/mps_pkg.sv */
`default_nettype none
package mps_pkg;

	localparam int PATTERN_MAX = 16;
	localparam int WIN_IDX_W = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
	localparam int LEN_W = 5;
	localparam int COUNT_W = 32;
	localparam int ADDR_W = 64;
	localparam int CFG_DATA_W = 64;
	localparam int CFG_IDX_W = 3;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PATTERN_LOW  = 3'd0,
		REG_PATTERN_HIGH = 3'd1,
		REG_PATTERN_LEN  = 3'd2,
		REG_SEARCH_MODE  = 3'd3,
		REG_BASE_ADDRESS = 3'd4
	} cfg_reg_t;

	typedef enum logic {
		MODE_FIND_EQUAL  = 1'b0,
		MODE_FIND_DIFFER = 1'b1
	} search_mode_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last;
	} in_item_t;

	typedef struct packed {
		logic              found;
		logic [ADDR_W-1:0] match_address;
	} out_item_t;

	typedef struct packed {
		logic [63:0]       pattern_low;
		logic [63:0]       pattern_high;
		logic [LEN_W-1:0]  pattern_len;
		search_mode_t      search_mode;
		logic [ADDR_W-1:0] base_address;
	} cfg_t;

endpackage
`default_nettype wire

/* hw/rtl/memory_pattern_search.sv */
`default_nettype none
// Path: an item is registered into item_s1 on accept, and a result it yields (a hit or
// the last item of a region) lands in the output register once the output side takes it.
// Throughput: one item per cycle while the output side takes results; the window
// compare against the pattern covers its first eff_len bytes, up to 16, in one pass.
// Reset (arst_n low, async) clears window, byte count, hit flag and valids;
// registers return to pattern 0, length 1, find mode, base address 0.
module memory_pattern_search (
	input  wire                             clk,
	input  wire                             arst_n,
	input  wire                             in_valid,
	output logic                            in_ready,
	input  mps_pkg::in_item_t               in_item,
	output logic                            out_valid,
	input  wire                             out_ready,
	output mps_pkg::out_item_t              out_item,
	input  wire                             cfg_we,
	input  wire  [mps_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire  [mps_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import mps_pkg::*;

	cfg_t      cfg;
	logic      res_ready;
	logic      res_push;
	out_item_t res_item;

	mps_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	mps_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_item   (in_item),
		.cfg       (cfg),
		.res_ready (res_ready),
		.res_push  (res_push),
		.res_item  (res_item)
	);

	mps_out u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.res_push  (res_push),
		.res_item  (res_item),
		.res_ready (res_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item)
	);

endmodule
`default_nettype wire

/* hw/rtl/mps_cfg.sv */
`default_nettype none
module mps_cfg (
	input  wire                                 clk,
	input  wire                                 arst_n,
	input  wire                                 cfg_we,
	input  wire  [mps_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  wire  [mps_pkg::CFG_DATA_W-1:0]      cfg_data,
	output mps_pkg::cfg_t                       cfg
);
	import mps_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.pattern_low  <= '0;
			cfg_q.pattern_high <= '0;
			cfg_q.pattern_len  <= LEN_W'(1);
			cfg_q.search_mode  <= MODE_FIND_EQUAL;
			cfg_q.base_address <= '0;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_PATTERN_LOW:  cfg_q.pattern_low  <= cfg_data[63:0];
				REG_PATTERN_HIGH: cfg_q.pattern_high <= cfg_data[63:0];
				REG_PATTERN_LEN:  cfg_q.pattern_len  <= cfg_data[LEN_W-1:0];
				REG_SEARCH_MODE:  cfg_q.search_mode  <= search_mode_t'(cfg_data[0]);
				REG_BASE_ADDRESS: cfg_q.base_address <= cfg_data[ADDR_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule
`default_nettype wire

/* hw/rtl/mps_core.sv */
`default_nettype none
module mps_core (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  in_valid,
	output logic                 in_ready,
	input  mps_pkg::in_item_t    in_item,
	input  mps_pkg::cfg_t        cfg,
	input  wire                  res_ready,
	output logic                 res_push,
	output mps_pkg::out_item_t   res_item
);
	import mps_pkg::*;

	logic             valid_s1;
	in_item_t         item_s1;
	logic             advance;

	logic [7:0]         win_q [PATTERN_MAX];
	logic [7:0]         win_n [PATTERN_MAX];
	logic [COUNT_W-1:0] count_q;
	logic [COUNT_W-1:0] count_n;
	logic               hit_done_q;

	logic [LEN_W-1:0]   eff_len;
	logic [LEN_W-1:0]   pos_k [PATTERN_MAX];
	logic [127:0]       pat;
	logic               equal;
	logic               hit;
	logic [COUNT_W-1:0] offset;

	assign advance  = valid_s1 && res_ready;
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= in_item;
		end
	end

	// window as it stands once this item's byte is shifted in
	always_comb begin
		win_n[0] = item_s1.data_byte;
		for (int i = 1; i < PATTERN_MAX; i++) begin
			win_n[i] = win_q[i-1];
		end
	end

	assign count_n = (count_q == '1) ? count_q : count_q + COUNT_W'(1);

	always_comb begin
		if (cfg.pattern_len == '0) begin
			eff_len = LEN_W'(1);
		end else if (cfg.pattern_len > LEN_W'(PATTERN_MAX)) begin
			eff_len = LEN_W'(PATTERN_MAX);
		end else begin
			eff_len = cfg.pattern_len;
		end
	end

	assign pat = {cfg.pattern_high, cfg.pattern_low};

	// pattern byte k lines up with the window byte len-1-k (newest at 0)
	always_comb begin
		equal = 1'b1;
		for (int k = 0; k < PATTERN_MAX; k++) begin
			pos_k[k] = eff_len - LEN_W'(1) - LEN_W'(k);
			if (LEN_W'(k) < eff_len) begin
				if (win_n[pos_k[k][WIN_IDX_W-1:0]] != pat[8*k +: 8]) begin
					equal = 1'b0;
				end
			end
		end
	end

	assign hit = (count_n >= COUNT_W'(eff_len)) &&
		((cfg.search_mode == MODE_FIND_DIFFER) ? !equal : equal);
	assign offset = count_n - COUNT_W'(eff_len);

	assign res_push = advance && !hit_done_q && (hit || item_s1.last);
	assign res_item.found = hit;
	assign res_item.match_address = hit ? cfg.base_address + ADDR_W'(offset) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < PATTERN_MAX; i++) begin
				win_q[i] <= '0;
			end
			count_q    <= '0;
			hit_done_q <= 1'b0;
		end else if (advance) begin
			if (item_s1.last) begin
				for (int i = 0; i < PATTERN_MAX; i++) begin
					win_q[i] <= '0;
				end
				count_q    <= '0;
				hit_done_q <= 1'b0;
			end else if (!hit_done_q) begin
				for (int i = 0; i < PATTERN_MAX; i++) begin
					win_q[i] <= win_n[i];
				end
				count_q <= count_n;
				if (hit) begin
					hit_done_q <= 1'b1;
				end
			end
		end
	end

	a_hit_sticks: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && hit_done_q && !item_s1.last) |=> hit_done_q)
		else $error("hit flag dropped inside a region");

	a_last_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && item_s1.last) |=> (count_q == '0 && !hit_done_q))
		else $error("state not cleared after last item");

	a_found_sets_done: assert property (@(posedge clk) disable iff (!arst_n)
		(res_push && res_item.found && !item_s1.last) |=> hit_done_q)
		else $error("hit reported without marking the region done");

	a_count_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && !item_s1.last) |=> (count_q >= $past(count_q)))
		else $error("byte count went backward inside a region");

endmodule
`default_nettype wire

/* hw/rtl/mps_out.sv */
`default_nettype none
module mps_out (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  res_push,
	input  mps_pkg::out_item_t   res_item,
	output logic                 res_ready,
	output logic                 out_valid,
	input  wire                  out_ready,
	output mps_pkg::out_item_t   out_item
);
	import mps_pkg::*;

	logic      out_valid_q;
	out_item_t out_item_q;

	assign res_ready = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_push) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_push) begin
			out_item_q <= res_item;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

endmodule
`default_nettype wire
